>>> rtl/spp_pkg.sv
package spp_pkg;

  localparam int MAX_BINS  = 2048;
  localparam int EHW       = 2;
  localparam int WIN_DEPTH = 2 * EHW + 1;
  localparam int BIN_W     = $clog2(MAX_BINS);
  localparam int NB_W      = 12;
  localparam int VAL_W     = 17;
  localparam int ESUM_W    = 19;
  localparam int SUM_W     = VAL_W + $clog2(WIN_DEPTH);
  localparam int QDEPTH    = 2;

  localparam logic [NB_W-1:0]   NUM_BINS_RESET  = 12'd2048;
  localparam logic [VAL_W-1:0]  THRESHOLD_RESET = 17'd32768;
  localparam logic [ESUM_W-1:0] ESUM_MAX        = 19'd524287;

  typedef enum logic [0:0] {
    REG_NUM_BINS  = 1'b0,
    REG_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [16:0] confidence;
    logic [16:0] energy;
  } in_item_t;

  typedef struct packed {
    logic        detection_valid;
    logic [23:0] bin_position;
    logic [16:0] frequency_q4;
    logic [16:0] peak_confidence;
    logic [18:0] peak_energy;
    logic [31:0] frame_index;
    logic        last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic              det;
    logic              last;
    logic [BIN_W-1:0]  c;
    logic [BIN_W-1:0]  nm1;
    logic [VAL_W-1:0]  conf_c;
    logic [VAL_W-1:0]  conf_l;
    logic [VAL_W-1:0]  conf_r;
    logic [ESUM_W-1:0] esum;
    logic [31:0]       frame;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFS_SETUP,
    ST_DIV,
    ST_DIV_END,
    ST_SQ,
    ST_POLY,
    ST_CONF,
    ST_FRQ_SETUP,
    ST_EXP,
    ST_POW,
    ST_LINH,
    ST_LIN,
    ST_SCALE,
    ST_DONE
  } back_state_t;

  localparam logic [24:0] ONE_Q24      = 25'd16777216;
  localparam logic [23:0] LN2_Q24      = 24'd11629080;
  localparam logic [18:0] LOG2_250_Q16 = 19'd522046;
  localparam logic [16:0] FREQ_MAX     = 17'd80000;

  function automatic logic [24:0] pow2_frac(input logic [2:0] idx);
    logic [24:0] v;
    case (idx)
      3'd0: v = 25'd23726566;
      3'd1: v = 25'd19951585;
      3'd2: v = 25'd18295684;
      3'd3: v = 25'd17520007;
      3'd4: v = 25'd17144589;
      3'd5: v = 25'd16959908;
      3'd6: v = 25'd16868315;
      3'd7: v = 25'd16822704;
      default: v = ONE_Q24;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/spp_queue.sv
module spp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spp_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output spp_pkg::job_t pop_data,
  output logic          empty
);
  import spp_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  job_t             slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W+1)'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/spp_front.sv
module spp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  spp_pkg::in_item_t in_data,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [16:0]       cfg_data,
  input  logic              q_full,
  output logic              push,
  output spp_pkg::job_t     push_job
);
  import spp_pkg::*;

  logic [VAL_W-1:0] conf_win [WIN_DEPTH];
  logic [VAL_W-1:0] en_win   [WIN_DEPTH];
  logic [VAL_W-1:0] conf_win_next [WIN_DEPTH];
  logic [VAL_W-1:0] en_win_next   [WIN_DEPTH];
  logic [BIN_W-1:0] bin_counter;
  logic [31:0]      frame_counter;
  logic [NB_W-1:0]  num_bins;
  logic [VAL_W-1:0] threshold;

  logic [BIN_W-1:0] nm1;
  logic             last;
  logic             accept;

  logic             cand   [1:EHW];
  logic [BIN_W-1:0] cand_c [1:EHW];
  logic [SUM_W-1:0] cand_e [1:EHW];

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    conf_win_next[0] = in_data.confidence;
    en_win_next[0]   = in_data.energy;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      conf_win_next[i] = conf_win[i-1];
      en_win_next[i]   = en_win[i-1];
    end
  end

  always_comb begin
    if (num_bins < NB_W'(3)) begin
      nm1 = BIN_W'(2);
    end else if (num_bins > NB_W'(MAX_BINS)) begin
      nm1 = BIN_W'(MAX_BINS - 1);
    end else begin
      nm1 = BIN_W'(num_bins - 1'b1);
    end
  end

  assign last = (bin_counter >= nm1);

  always_comb begin
    logic [VAL_W-1:0] cc, ll, rr;
    logic [SUM_W-1:0] acc;
    for (int d0 = 1; d0 <= EHW; d0++) begin
      cand_c[d0] = bin_counter - BIN_W'(d0);
      cc = conf_win_next[d0];
      ll = conf_win_next[d0+1];
      rr = conf_win_next[d0-1];
      cand[d0] = (bin_counter >= BIN_W'(d0)) && (cand_c[d0] != '0) && (cand_c[d0] < nm1)
                 && (cc >= threshold) && (cc > ll) && (cc > rr);
      acc = '0;
      for (int s = 0; s < WIN_DEPTH; s++) begin
        if ((bin_counter >= BIN_W'(s)) && (s + EHW >= d0) && (s <= d0 + EHW)
            && ((bin_counter - BIN_W'(s)) <= nm1)) begin
          acc = acc + SUM_W'(en_win_next[s]);
        end
      end
      cand_e[d0] = acc;
    end
  end

  always_comb begin
    logic             found;
    logic [SUM_W-1:0] esel;
    found    = 1'b0;
    esel     = '0;
    push_job = '0;
    for (int d0 = EHW; d0 >= 1; d0--) begin
      if (!found && cand[d0] && (last || d0 == EHW)) begin
        found           = 1'b1;
        push_job.c      = cand_c[d0];
        push_job.conf_c = conf_win_next[d0];
        push_job.conf_l = conf_win_next[d0+1];
        push_job.conf_r = conf_win_next[d0-1];
        esel            = cand_e[d0];
      end
    end
    push_job.det   = found;
    push_job.last  = last;
    push_job.nm1   = nm1;
    push_job.frame = frame_counter;
    push_job.esum  = (esel > SUM_W'(ESUM_MAX)) ? ESUM_MAX : ESUM_W'(esel);
    push           = accept && (found || last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        conf_win[i] <= '0;
        en_win[i]   <= '0;
      end
      bin_counter   <= '0;
      frame_counter <= '0;
      num_bins      <= NUM_BINS_RESET;
      threshold     <= THRESHOLD_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_BINS:  num_bins  <= cfg_data[NB_W-1:0];
          REG_THRESHOLD: threshold <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        conf_win <= conf_win_next;
        en_win   <= en_win_next;
        if (last) begin
          bin_counter   <= '0;
          frame_counter <= frame_counter + 1'b1;
        end else begin
          bin_counter <= bin_counter + 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/spp_back.sv
module spp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  spp_pkg::job_t      q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output spp_pkg::out_item_t out_data
);
  import spp_pkg::*;

  localparam int DVD_W = 40;
  localparam int DVS_W = 20;
  localparam int Q_W   = 17;

  back_state_t state, state_next;
  job_t        job;

  logic              div_frq;
  logic [DVD_W-1:0]  rem;
  logic [DVD_W-1:0]  dsh;
  logic [Q_W-1:0]    quot;
  logic [4:0]        cnt;

  logic signed [13:0] ofs;
  logic [24:0]        xx;
  logic signed [31:0] bx;
  logic signed [45:0] ax2;
  logic [16:0]        yconf;
  logic [23:0]        pos;
  logic [16:0]        rq;
  logic [19:0]        ex;
  logic [2:0]         pcnt;
  logic [25:0]        mant;
  logic [24:0]        hh;
  logic [16:0]        frq;

  logic               interp;
  logic signed [17:0] bdiff;
  logic signed [18:0] acurv;
  logic [18:0]        dpos;
  logic [28:0]        mag;
  logic [23:0]        pos_calc;
  logic [DVD_W-1:0]   dvd_in;
  logic [DVS_W-1:0]   dvs_in;
  logic               div_ovf;
  logic               ge;
  logic               out_load;

  assign interp = (job.conf_l != '0) && (job.conf_r != '0);
  assign bdiff  = $signed({1'b0, job.conf_r}) - $signed({1'b0, job.conf_l});
  assign acurv  = $signed({2'b0, job.conf_l}) + $signed({2'b0, job.conf_r})
                  - $signed({1'b0, job.conf_c, 1'b0});
  assign dpos   = 19'(-acurv);
  assign mag    = {(bdiff[17] ? 17'(-bdiff) : bdiff[16:0]), 12'b0};
  assign pos_calc = {1'b0, job.c, 12'b0} + {{10{ofs[13]}}, ofs};

  always_comb begin
    if (state == ST_FRQ_SETUP) begin
      dvd_in = DVD_W'({pos_calc, 5'b0}) + DVD_W'(job.nm1);
      dvs_in = DVS_W'({job.nm1, 1'b0});
    end else begin
      dvd_in = DVD_W'(mag) + DVD_W'(dpos);
      dvs_in = {dpos, 1'b0};
    end
    div_ovf = dvd_in >= (DVD_W'(dvs_in) << Q_W);
  end

  assign ge = rem >= dsh;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (!q_empty) state_next = q_data.det ? ST_OFS_SETUP : ST_DONE;
      ST_OFS_SETUP: state_next = interp ? (div_ovf ? ST_DIV_END : ST_DIV) : ST_FRQ_SETUP;
      ST_DIV:       if (cnt == '0) state_next = ST_DIV_END;
      ST_DIV_END:   state_next = div_frq ? ST_EXP : ST_SQ;
      ST_SQ:        state_next = ST_POLY;
      ST_POLY:      state_next = ST_CONF;
      ST_CONF:      state_next = ST_FRQ_SETUP;
      ST_FRQ_SETUP: state_next = div_ovf ? ST_DIV_END : ST_DIV;
      ST_EXP:       state_next = ST_POW;
      ST_POW:       if (pcnt == 3'd7) state_next = ST_LINH;
      ST_LINH:      state_next = ST_LIN;
      ST_LIN:       state_next = ST_SCALE;
      ST_SCALE:     state_next = ST_DONE;
      ST_DONE:      if (out_load) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == ST_IDLE) && !q_empty;
    out_load = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [12:0]        qc;
    logic signed [27:0] sq_full;
    logic signed [45:0] ax_full;
    logic signed [46:0] csum;
    logic signed [23:0] ytmp;
    logic [35:0]        e_full;
    logic [50:0]        mprod;
    logic [32:0]        lin_full;
    logic [49:0]        scaled;
    logic [25:0]        fround;
    qc       = (quot >= Q_W'(4096)) ? 13'd4096 : quot[12:0];
    sq_full  = 28'(ofs) * 28'(ofs);
    ax_full  = 46'(acurv) * $signed({21'b0, xx});
    csum     = 47'(ax2) + (47'(bx) <<< 12) + 47'sd16777216;
    ytmp     = $signed({7'b0, job.conf_c}) + 24'(csum >>> 25);
    e_full   = 36'(rq) * 36'(LOG2_250_Q16) + 36'd32768;
    mprod    = 51'(mant) * 51'(pow2_frac(pcnt)) + 51'd8388608;
    lin_full = 33'(ex[7:0]) * 33'(LN2_Q24) + 33'd32768;
    scaled   = ((50'(mant) * 50'd320) << ex[19:16]) + 50'd8388608;
    fround   = scaled[49:24];
    if (out_load) begin
      out_data.detection_valid <= job.det;
      out_data.bin_position    <= job.det ? pos : '0;
      out_data.frequency_q4    <= job.det ? frq : '0;
      out_data.peak_confidence <= job.det ? yconf : '0;
      out_data.peak_energy     <= job.det ? job.esum : '0;
      out_data.frame_index     <= job.frame;
      out_data.last_of_frame   <= job.last;
    end
    case (state)
      ST_IDLE: begin
        if (!q_empty) job <= q_data;
      end
      ST_OFS_SETUP: begin
        ofs     <= '0;
        yconf   <= job.conf_c;
        div_frq <= 1'b0;
        rem     <= dvd_in;
        dsh     <= DVD_W'(dvs_in) << (Q_W - 1);
        cnt     <= 5'(Q_W - 1);
        quot    <= div_ovf ? '1 : '0;
      end
      ST_DIV: begin
        rem  <= ge ? rem - dsh : rem;
        quot <= {quot[Q_W-2:0], ge};
        dsh  <= dsh >> 1;
        cnt  <= cnt - 1'b1;
      end
      ST_DIV_END: begin
        if (div_frq) begin
          rq <= (quot > Q_W'(65536)) ? 17'd65536 : quot;
        end else begin
          ofs <= bdiff[17] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        end
      end
      ST_SQ: begin
        xx <= 25'(sq_full);
        bx <= 32'(bdiff) * 32'(ofs);
      end
      ST_POLY: begin
        ax2 <= ax_full;
      end
      ST_CONF: begin
        if (ytmp < 0) begin
          yconf <= '0;
        end else if (ytmp > 24'sd65536) begin
          yconf <= 17'd65536;
        end else begin
          yconf <= ytmp[16:0];
        end
      end
      ST_FRQ_SETUP: begin
        pos     <= pos_calc;
        div_frq <= 1'b1;
        rem     <= dvd_in;
        dsh     <= DVD_W'(dvs_in) << (Q_W - 1);
        cnt     <= 5'(Q_W - 1);
        quot    <= div_ovf ? '1 : '0;
      end
      ST_EXP: begin
        ex   <= e_full[35:16];
        mant <= 26'(ONE_Q24);
        pcnt <= '0;
      end
      ST_POW: begin
        if (ex[4'd15 - {1'b0, pcnt}]) mant <= mprod[49:24];
        pcnt <= pcnt + 1'b1;
      end
      ST_LINH: begin
        hh <= ONE_Q24 + 25'(lin_full[32:16]);
      end
      ST_LIN: begin
        mprod = 51'(mant) * 51'(hh) + 51'd8388608;
        mant  <= mprod[49:24];
      end
      ST_SCALE: begin
        frq <= (fround > 26'(FREQ_MAX)) ? FREQ_MAX : fround[16:0];
      end
      default: ;
    endcase
  end

  a_ofs_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ) |-> (ofs <= 14'sd4096) && (ofs >= -14'sd4096))
    else $error("offset beyond one bin");

  a_freq_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.detection_valid |->
      (out_data.frequency_q4 >= 17'd320) && (out_data.frequency_q4 <= FREQ_MAX))
    else $error("frequency out of range");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.detection_valid |-> out_data.last_of_frame)
    else $error("empty transaction not at frame end");

endmodule

>>> rtl/spectral_peak_picker_parabolic.sv
// a bin with no result pushes no job; a frame-end transaction without a peak goes from
// the queue straight to the output, a detection first runs the offset and frequency steps
// throughput: one bin per cycle while the two-entry job queue has room; each detection
// holds the back end through one or two 17-step divisions on a shared divider and the
// power series; reset (synchronous, rst high) clears windows, counters, queue and output
// valid, and loads num_bins 2048 and confidence_threshold 32768
module spectral_peak_picker_parabolic (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  spp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spp_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import spp_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t pop_job;

  spp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  spp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_data (pop_job),
    .empty    (q_empty)
  );

  spp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (pop_job),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_NUM_BINS;
  logic [16:0] cfg_data = '0;

  spectral_peak_picker_parabolic u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [16:0] conf_win [WIN_DEPTH];
  logic [16:0] nrg_win [WIN_DEPTH];
  int unsigned bin_cnt;
  logic [31:0] frame_cnt;
  logic [11:0] nbins_reg;
  logic [16:0] thresh_reg;
  out_item_t peak_q[$];

  int errors = 0;
  int idle_pct = 17;
  int stall_pct = 17;
  int quiet = 0;

  localparam longint unsigned POW2_TAB [8] = '{23726566, 19951585, 18295684, 17520007,
                                             17144589, 16959908, 16868315, 16822704};

  function automatic longint signed fshift25(longint signed t);
    if (t >= 0) return t >>> 25;
    return -(((-t) + (64'd1 << 25) - 1) >> 25);
  endfunction

  function automatic logic [16:0] pos_to_freq(longint unsigned pos, longint unsigned n);
    longint unsigned d, r, e, m, g, f, ip;
    d = n - 1;
    r = (pos * 32 + d) / (2 * d);
    if (r > 65536) r = 65536;
    e = (r * 522046 + 32768) >> 16;
    ip = e >> 16;
    f = e & 16'hFFFF;
    m = 64'd16777216;
    for (int k = 0; k < 8; k++)
      if (f & (64'h8000 >> k)) m = (m * POW2_TAB[k] + (64'd1 << 23)) >> 24;
    g = f & 8'hFF;
    m = (m * (64'd16777216 + ((g * 11629080 + 32768) >> 16)) + (64'd1 << 23)) >> 24;
    f = ((320 * m << (ip & 15)) + (64'd1 << 23)) >> 24;
    return (f > 80000) ? 17'd80000 : f[16:0];
  endfunction

  function automatic bit peak_at(int d0, int k, int n, ref out_item_t o);
    int c, lo, hi;
    longint signed cc, ll, rr, x, y, num;
    longint unsigned den, mag, esum, pos;
    if (d0 > k) return 0;
    c = k - d0;
    if (c < 1 || c > n - 2) return 0;
    cc = conf_win[d0];
    ll = conf_win[d0 + 1];
    rr = conf_win[d0 - 1];
    if (cc < thresh_reg || cc <= ll || cc <= rr) return 0;
    x = 0;
    y = cc;
    if (ll > 0 && rr > 0) begin
      num = rr - ll;
      den = 2 * (2 * cc - ll - rr);
      mag = (num < 0 ? -num : num) * 4096;
      x = (2 * mag + den) / (2 * den);
      if (num < 0) x = -x;
      if (x > 4096) x = 4096;
      if (x < -4096) x = -4096;
      y = cc + fshift25((ll + rr - 2 * cc) * x * x + (rr - ll) * x * 4096 + (64'sd1 << 24));
      if (y < 0) y = 0;
      if (y > 65536) y = 65536;
    end
    lo = (c >= EHW) ? c - EHW : 0;
    hi = c + EHW;
    if (hi > n - 1) hi = n - 1;
    if (hi > k) hi = k;
    esum = 0;
    for (int j = lo; j <= hi; j++) esum += nrg_win[k - j];
    if (esum > 524287) esum = 524287;
    pos = c * 4096 + x;
    o.detection_valid = 1'b1;
    o.bin_position = pos[23:0];
    o.frequency_q4 = pos_to_freq(pos[31:0], n);
    o.peak_confidence = y[16:0];
    o.peak_energy = esum[18:0];
    return 1;
  endfunction

  function automatic void predict_bin(in_item_t it);
    out_item_t o;
    int n, k;
    bit last, found;
    for (int i = WIN_DEPTH - 1; i > 0; i--) begin
      conf_win[i] = conf_win[i - 1];
      nrg_win[i] = nrg_win[i - 1];
    end
    conf_win[0] = it.confidence;
    nrg_win[0] = it.energy;
    n = nbins_reg;
    if (n < 3) n = 3;
    if (n > MAX_BINS) n = MAX_BINS;
    k = bin_cnt;
    last = (k >= n - 1);
    o = '0;
    found = 0;
    if (last) begin
      for (int d0 = EHW; d0 >= 1 && !found; d0--) found = peak_at(d0, k, n, o);
    end else begin
      found = peak_at(EHW, k, n, o);
    end
    o.frame_index = frame_cnt;
    o.last_of_frame = last;
    if (found || last) peak_q = {peak_q, o};
    if (last) begin
      bin_cnt = 0;
      frame_cnt++;
    end else begin
      bin_cnt = k + 1;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (peak_q.size() == 0) begin
          $display("%0t: unexpected transaction %p", $time, out_data);
          errors++;
        end else begin
          out_item_t e;
          e = peak_q.pop_front();
          if (out_data !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_bin(logic [16:0] conf, logic [16:0] nrg);
    in_item_t it;
    it.confidence = conf;
    it.energy = nrg;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_bin(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (peak_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [16:0] val);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NUM_BINS) nbins_reg = val[11:0];
    else thresh_reg = val;
    @(posedge clk);
  endtask

  task automatic finish_frame();
    while (bin_cnt != 0) send_bin(17'($urandom_range(65536)), 17'($urandom_range(65536)));
  endtask

  task automatic test_directed();
    write_reg(REG_NUM_BINS, 17'd8);
    write_reg(REG_THRESHOLD, 17'd0);
    send_bin(17'd0, 17'd65536);
    send_bin(17'd65536, 17'd65536);
    send_bin(17'd100, 17'd0);
    send_bin(17'd40000, 17'h1FFFF);
    send_bin(17'd60000, 17'h1FFFF);
    send_bin(17'd20000, 17'h1FFFF);
    send_bin(17'h1FFFF, 17'h1FFFF);
    send_bin(17'd5, 17'h1FFFF);
    // peak at second-last bin, decided at frame end
    drain();
    write_reg(REG_NUM_BINS, 17'd5);
    send_bin(17'd1, 17'd3);
    send_bin(17'd2, 17'd3);
    send_bin(17'd1, 17'd3);
    send_bin(17'd9, 17'd3);
    send_bin(17'd0, 17'd3);
    drain();
    // out-of-range sizes clamp
    write_reg(REG_NUM_BINS, 17'd0);
    write_reg(REG_THRESHOLD, 17'd65536);
    send_bin(17'd0, 17'd1);
    send_bin(17'd65536, 17'd1);
    send_bin(17'd0, 17'd1);
    drain();
  endtask

  task automatic test_lowered_size();
    write_reg(REG_NUM_BINS, 17'd40);
    write_reg(REG_THRESHOLD, 17'd1000);
    repeat (20) send_bin(17'($urandom_range(65536)), 17'($urandom_range(65536)));
    drain();
    write_reg(REG_NUM_BINS, 17'd6);
    send_bin(17'd3, 17'd3);
    drain();
  endtask

  task automatic test_random(int items);
    int nb;
    for (int i = 0; i < items; i++) begin
      if (bin_cnt == 0 && $urandom_range(30) == 0) begin
        drain();
        nb = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 24);
        write_reg(REG_NUM_BINS, nb[16:0]);
        write_reg(REG_THRESHOLD,
                  17'($urandom_range(3) == 0 ? $urandom : $urandom_range(65536)));
      end
      idle_pct = (i > items / 2 && i < items / 2 + 200) ? 0 : 17;
      stall_pct = idle_pct;
      case ($urandom_range(3))
        0: send_bin(17'($urandom), 17'($urandom));
        default: send_bin(17'($urandom_range(65536)), 17'($urandom_range(65536)));
      endcase
    end
    finish_frame();
  endtask

  task automatic test_full_frame();
    drain();
    write_reg(REG_NUM_BINS, 17'd300);
    write_reg(REG_THRESHOLD, 17'd0);
    for (int i = 0; i < 300; i++)
      send_bin((i % 37 == 18) ? 17'd65536 : 17'($urandom_range(30000)),
               17'($urandom_range(65536)));
  endtask

  initial begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      conf_win[i] = '0;
      nrg_win[i] = '0;
    end
    bin_cnt = 0;
    frame_cnt = '0;
    nbins_reg = NUM_BINS_RESET;
    thresh_reg = THRESHOLD_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_lowered_size();
    test_random(1150);
    test_full_frame();
    drain();
    if (errors == 0 && peak_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/spp_pkg.sv
rtl/spp_queue.sv
rtl/spp_front.sv
rtl/spp_back.sv
rtl/spectral_peak_picker_parabolic.sv
tb/tb.sv
